// File: rtl/core/fdmn_pkg.sv
// Shared types and constants for the divide-by-constant parameter generator.
package fdmn_pkg;

  // Field widths of the input and result words.
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned SH_W   = 5;
  localparam int unsigned STEP_W = 7;
  localparam int unsigned OUT_W  = 40;

  // Index of the top divisor bit, used to turn a zero count into a bit position.
  localparam logic [SH_W-1:0] MSB_TOP = 5'd31;

  // The division always runs past the 32 fraction bits plus the leading position.
  localparam logic [STEP_W-1:0] DIV_BASE_STEPS = 7'd33;

  // Multiplier used for every power of two.
  localparam logic [DIV_W-1:0] POW2_MULT = 32'h8000_0000;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FIN
  } fdmn_state_t;

  // Status of the leading-one search.
  typedef struct packed {
    logic            done;
    logic            zero;
    logic            pow2;
    logic [SH_W-1:0] msb;
  } scan_res_t;

  // Status and result of the serial divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_res_t;

endpackage

// File: rtl/core/fdmn_scan.sv
// Serial leading-one search: shifts the divisor left one bit per cycle.
module fdmn_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fdmn_pkg::DIV_W-1:0] divisor,
  output fdmn_pkg::scan_res_t       res
);
  import fdmn_pkg::*;

  logic [DIV_W-1:0] sh_r, sh_nxt;
  logic [SH_W-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             is_zero;
  logic             found;

  // The search ends on an empty word or once the top bit is set.
  assign is_zero = (sh_r == '0);
  assign found   = sh_r[DIV_W-1];

  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      sh_nxt   = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (is_zero || found) begin
        busy_nxt = 1'b0;
      end else begin
        sh_nxt  = {sh_r[DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  // A power of two has nothing below the leading one.
  always_comb begin
    res.done = busy_r && (is_zero || found);
    res.zero = is_zero;
    res.pow2 = (sh_r[DIV_W-2:0] == '0);
    res.msb  = MSB_TOP - cnt_r;
  end

endmodule

// File: rtl/core/fdmn_div.sv
// Bit-serial restoring divider for a power of two over a 32-bit divisor.
module fdmn_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fdmn_pkg::STEP_W-1:0] steps,
  input  logic [fdmn_pkg::DIV_W-1:0]  divisor,
  output fdmn_pkg::div_res_t         res
);
  import fdmn_pkg::*;

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              first_r, first_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    part;
  logic [DIV_W+1:0]  trial;
  logic              ge;

  // The dividend is a single one followed by zeros, so the first bit in is one.
  assign part  = {rem_r, first_r};
  assign trial = {1'b0, part} - {2'b00, divisor};
  assign ge    = ~trial[DIV_W+1];

  always_comb begin
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      rem_nxt   = '0;
      quo_nxt   = '0;
      cnt_nxt   = steps;
      first_nxt = 1'b1;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      rem_nxt   = ge ? trial[DIV_W-1:0] : part[DIV_W-1:0];
      quo_nxt   = {quo_r[DIV_W-2:0], ge};
      cnt_nxt   = cnt_r - 1'b1;
      first_nxt = 1'b0;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
  end

  always_comb begin
    res.done = done_r;
    res.quo  = quo_r;
    res.rem  = rem_r;
  end

endmodule

// File: rtl/core/fast_division_magic_number.sv
// Top level: turns a 32-bit divisor into multiply-and-shift division parameters.
//
//   channel  dir  word contents (low bit first)
//   in_      in   divisor[31:0]
//   out_     out  multiplier[31:0], post_shift[36:32], add_one_to_dividend[37],
//                 divisor_not_one[38], zero_divisor_error[39]
//
// One word is worked on at a time. The leading-one search finds m, the index of the top
// set divisor bit, then the serial divider runs, and the FIN state loads the result into
// the output register. A zero divisor or a power of two skips the divider. Reset clears
// the sequencer and the output valid. The next word is taken while a result waits in the
// output register; its result then waits in FIN.
module fast_division_magic_number (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // divisor[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // multiplier[31:0], post_shift[36:32],
                                  // add_one_to_dividend[37], divisor_not_one[38],
                                  // zero_divisor_error[39]
);
  import fdmn_pkg::*;

  fdmn_state_t      state_r, state_nxt;
  logic [DIV_W-1:0] d_r;
  logic             zero_r, pow2_r;
  logic [SH_W-1:0]  msb_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic             in_acc;
  logic             out_free;
  logic             div_start;
  logic             out_load;
  logic [STEP_W-1:0] div_steps;
  scan_res_t        scan_res;
  div_res_t         div_res;

  logic [DIV_W-1:0] fin_mult;
  logic [SH_W-1:0]  fin_shift;
  logic             fin_inc;
  logic             fin_not_one;
  logic [DIV_W:0]   rem_plus_half;
  logic             round_down;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign div_steps = DIV_BASE_STEPS + STEP_W'(scan_res.msb);

  // Leading-one search and serial divider.
  fdmn_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .divisor (in_tdata),
    .res     (scan_res)
  );

  fdmn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .steps   (div_steps),
    .divisor (d_r),
    .res     (div_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = (scan_res.zero || scan_res.pow2) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV:  if (div_res.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: div_start = scan_res.done && !scan_res.zero && !scan_res.pow2;
      ST_DIV:  ;
      ST_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  // The multiplier rounds down when the remainder plus half the divisor
  // stays below the divisor; the dividend then gets the increment.
  assign rem_plus_half = {1'b0, div_res.rem} + {2'b00, d_r[DIV_W-1:1]};
  assign round_down    = (rem_plus_half < {1'b0, d_r});

  // Result word.
  always_comb begin
    fin_mult    = '0;
    fin_shift   = '0;
    fin_inc     = 1'b0;
    fin_not_one = 1'b0;
    if (zero_r) begin
      fin_mult = '0;
    end else if (pow2_r) begin
      fin_mult    = POW2_MULT;
      fin_shift   = (msb_r == '0) ? '0 : msb_r - 1'b1;
      fin_not_one = (msb_r != '0);
    end else begin
      fin_mult    = round_down ? div_res.quo : div_res.quo + 1'b1;
      fin_shift   = msb_r;
      fin_inc     = round_down;
      fin_not_one = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      d_r <= in_tdata;
    end
    if (state_r == ST_SCAN && scan_res.done) begin
      zero_r <= scan_res.zero;
      pow2_r <= scan_res.pow2;
      msb_r  <= scan_res.msb;
    end
    if (out_load) begin
      out_data_r <= {zero_r, fin_not_one, fin_inc, fin_shift, fin_mult};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
